@@ hw/rtl/ultrasonic_echo_ranger_macros.svh @@
// ----------------------------------------------------------------------------
// ultrasonic echo ranger assertion macros
// shorthand for clocked checks that sample on clk and are off during rst
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UER_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define UER_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// uer_pkg
// shared types, constants and command codes of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uer_pkg;

  // default tick counter width
  localparam int UER_COUNT_WIDTH = 16;

  // apb register file
  localparam int UER_ADDR_W    = 5;
  localparam int UER_DATA_W    = 32;
  localparam int UER_IDX_W     = UER_ADDR_W - 2;

  typedef enum logic [UER_IDX_W-1:0] {
    REG_TRIGGER_TICKS = 3'd0,
    REG_TIMEOUT_TICKS = 3'd1,
    REG_SPACING_MM    = 3'd2,
    REG_OFFSET_MM     = 3'd3,
    REG_THRESHOLD_MM  = 3'd4
  } uer_reg_t;

  // register reset values
  localparam logic [7:0]  UER_TRIGGER_RESET   = 8'd1;
  localparam logic [15:0] UER_TIMEOUT_RESET   = 16'hFFFF;
  localparam logic [9:0]  UER_SPACING_RESET   = 10'd0;
  localparam logic [7:0]  UER_OFFSET_RESET    = 8'd12;
  localparam logic [15:0] UER_THRESHOLD_RESET = 16'd0;

  // distance arithmetic: d = isqrt((17c)^2 - 100 s^2) / 20 + offset
  localparam int          UER_ECHO_SCALE    = 17;
  localparam int          UER_SPACING_SCALE = 100;
  // root / 20 = (root >> 2) / 5, and /5 is a multiply by ceil(2^21 / 5)
  localparam logic [18:0] UER_RECIP_5       = 19'd419431;
  localparam int          UER_RECIP_SHIFT   = 21;
  // roots at or above 20 * 65536 always saturate the distance
  localparam logic [31:0] UER_SAT_ROOT      = 32'd1310720;
  localparam logic [15:0] UER_DIST_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] timeout_ticks;
    logic [9:0]  module_spacing_mm;
    logic [7:0]  offset_mm;
    logic [15:0] near_threshold_mm;
  } uer_cfg_t;

  // channel payloads
  typedef struct packed {
    logic start_req;
    logic echo_level;
  } uer_tick_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] distance_mm;
    logic        far_flag;
    logic        near_flag;
  } uer_result_t;

  // tick counter operations
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_LOAD1,
    CNT_CLEAR,
    CNT_UP
  } uer_cnt_op_t;

  // distance calculation steps
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_SQ_A,
    STEP_SQ_LL,
    STEP_SQ_HL,
    STEP_SQ_HH,
    STEP_SQ_ACC,
    STEP_RAD,
    STEP_ROOT_GO,
    STEP_DIV
  } uer_step_t;

  // how a measurement ends
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_TIMEOUT,
    FIN_OK
  } uer_fin_t;

  // controller to datapath
  typedef struct packed {
    uer_cnt_op_t cnt_op;
    uer_step_t   step;
    uer_fin_t    fin;
    logic        out_load;
    logic        out_trig;
    logic        out_busy;
    logic        out_done;
  } uer_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trig_done;
    logic up_timeout;
    logic one_timeout;
    logic root_done;
  } uer_stat_t;

endpackage

@@ hw/rtl/uer_channels.sv @@
// ----------------------------------------------------------------------------
// uer channels
// valid/ready stream interfaces for time-base ticks and ranging results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface uer_tick_if;
  import uer_pkg::*;

  logic      valid;
  logic      ready;
  uer_tick_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface uer_result_if;
  import uer_pkg::*;

  logic        valid;
  logic        ready;
  uer_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// ----------------------------------------------------------------------------
// ultrasonic echo ranger
// Feed one tick transfer per time-base tick, carrying the start request and
// the sampled echo level; each tick returns exactly one result transfer with
// the trigger level to drive, busy and done, and the last distance with its
// timeout, far and near flags. A tick is taken only in a cycle where the
// output register is empty or its result transfer leaves in that same cycle.
// The tick on which the echo falls is followed by the distance calculation
// before its result is valid and the next tick can be taken: states ST_SQ_A
// to ST_RAD form 17 * count, build its square from three 16 x 16 partial
// products (the cross product taken twice) and clamp the radicand, ST_ROOT_GO
// starts the square-root unit, which retires one root bit per cycle and
// reports done in the cycle after the last bit, and ST_DIV and ST_FINISH do
// the divide by 20, then the offset and saturation. Configuration is written
// over the apb port at byte address 4 * index; the user must write it only
// while no tick is in work, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = uer_pkg::UER_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  uer_tick_if.sink                       tick,
  uer_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [uer_pkg::UER_ADDR_W-1:0] paddr,
  input  logic [uer_pkg::UER_DATA_W-1:0] pwdata,
  output logic [uer_pkg::UER_DATA_W-1:0] prdata,
  output logic                           pready
);
  import uer_pkg::*;

  uer_cfg_t    cfg;
  uer_cmd_t    cmd;
  uer_stat_t   st;
  uer_result_t res;
  logic        tick_ready;
  logic        res_valid;

  // configuration registers
  uer_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // phase tracking and sequencing
  uer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_start (tick.payload.start_req),
    .tick_echo  (tick.payload.echo_level),
    .tick_ready (tick_ready),
    .res_valid  (res_valid),
    .res_ready  (result.ready),
    .cmd        (cmd),
    .st         (st)
  );

  // counter and distance arithmetic
  uer_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .st  (st),
    .res (res)
  );

  assign tick.ready     = tick_ready;
  assign result.valid   = res_valid;
  assign result.payload = res;

endmodule

@@ hw/rtl/uer_cfg.sv @@
// ----------------------------------------------------------------------------
// uer_cfg
// apb register file holding the ranging configuration
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uer_pkg::UER_ADDR_W-1:0] paddr,
  input  logic [uer_pkg::UER_DATA_W-1:0] pwdata,
  output logic [uer_pkg::UER_DATA_W-1:0] prdata,
  output logic                          pready,
  output uer_pkg::uer_cfg_t             cfg
);
  import uer_pkg::*;

  uer_reg_t reg_idx;
  logic     wr_en;

  assign reg_idx = uer_reg_t'(paddr[UER_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes, out-of-range addresses ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks     <= UER_TRIGGER_RESET;
      cfg.timeout_ticks     <= UER_TIMEOUT_RESET;
      cfg.module_spacing_mm <= UER_SPACING_RESET;
      cfg.offset_mm         <= UER_OFFSET_RESET;
      cfg.near_threshold_mm <= UER_THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TRIGGER_TICKS: cfg.trigger_ticks     <= pwdata[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks     <= pwdata[15:0];
        REG_SPACING_MM:    cfg.module_spacing_mm <= pwdata[9:0];
        REG_OFFSET_MM:     cfg.offset_mm         <= pwdata[7:0];
        REG_THRESHOLD_MM:  cfg.near_threshold_mm <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TRIGGER_TICKS: prdata = UER_DATA_W'(cfg.trigger_ticks);
      REG_TIMEOUT_TICKS: prdata = UER_DATA_W'(cfg.timeout_ticks);
      REG_SPACING_MM:    prdata = UER_DATA_W'(cfg.module_spacing_mm);
      REG_OFFSET_MM:     prdata = UER_DATA_W'(cfg.offset_mm);
      REG_THRESHOLD_MM:  prdata = UER_DATA_W'(cfg.near_threshold_mm);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/uer_isqrt.sv @@
// ----------------------------------------------------------------------------
// uer_isqrt
// iterative integer square root, one root bit per cycle, rounded down
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_isqrt #(
  parameter int ROOT_W = uer_pkg::UER_COUNT_WIDTH + 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root,
  output logic                  done
);
  localparam int SQ_W = 2 * ROOT_W;
  localparam int IT_W = $clog2(ROOT_W);

  logic [SQ_W-1:0]   rad_sh;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;
  logic              busy;
  logic [IT_W-1:0]   iter;

  // bring down the next two radicand bits and try the next root bit
  assign rem_sh = {rem[ROOT_W-1:0], rad_sh[SQ_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= IT_W'(ROOT_W - 1);
      end else if (busy) begin
        if (iter == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter - 1'b1;
        end
      end
    end
  end

  // remainder and partial root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[SQ_W-3:0], 2'b00};
      rem    <= ge ? (rem_sh - trial) : rem_sh;
      root   <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/uer_datapath.sv @@
// ----------------------------------------------------------------------------
// uer_datapath
// tick counter, distance arithmetic, stored measurement and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uer_datapath #(
  parameter int COUNT_WIDTH = uer_pkg::UER_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  uer_pkg::uer_cfg_t    cfg,
  input  uer_pkg::uer_cmd_t    cmd,
  output uer_pkg::uer_stat_t   st,
  output uer_pkg::uer_result_t res
);
  import uer_pkg::*;

  // 17 * count fits in COUNT_WIDTH + 5 bits, its square in twice that
  localparam int A_W  = COUNT_WIDTH + 5;
  localparam int SQ_W = 2 * A_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] cnt_up;

  logic [31:0]   a_reg;
  logic [15:0]   a_lo;
  logic [15:0]   a_hi;
  logic [19:0]   ss_reg;
  logic [26:0]   sub_reg;
  logic [31:0]   prod;
  logic [63:0]   acc;
  logic [SQ_W-1:0] rad;
  logic [A_W-1:0]  root;
  logic            root_done;
  logic [18:0]   quarter;
  logic [37:0]   div_prod;
  logic [15:0]   quot;
  logic          big;
  logic [16:0]   sum;
  logic [15:0]   dist_ok;

  logic [15:0]   last_distance;
  logic          timeout_seen;
  logic          far_flag;
  logic          near_flag;
  logic [15:0]   last_distance_next;
  logic          timeout_seen_next;
  logic          far_flag_next;
  logic          near_flag_next;

  // saturating increment and the compares the controller branches on
  assign cnt_up         = (tick_count != CNT_MAX) ? tick_count + 1'b1 : tick_count;
  assign st.trig_done   = 32'(tick_count) >= 32'(cfg.trigger_ticks);
  assign st.up_timeout  = (32'(cnt_up) >= 32'(cfg.timeout_ticks)) || (cnt_up == CNT_MAX);
  assign st.one_timeout = cfg.timeout_ticks <= 16'd1;
  assign st.root_done   = root_done;

  // tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_LOAD1: tick_count <= COUNT_WIDTH'(1);
        CNT_CLEAR: tick_count <= '0;
        CNT_UP:    tick_count <= cnt_up;
        default:   tick_count <= tick_count;
      endcase
    end
  end

  // squaring in 16 x 16 partial products, one per cycle
  assign a_lo     = a_reg[15:0];
  assign a_hi     = a_reg[31:16];
  assign quarter  = 19'(32'(root) >> 2);
  assign div_prod = 38'(quarter) * 38'(UER_RECIP_5);

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      STEP_SQ_A: begin
        a_reg  <= 32'(tick_count) * 32'(UER_ECHO_SCALE);
        ss_reg <= 20'(cfg.module_spacing_mm) * 20'(cfg.module_spacing_mm);
      end
      STEP_SQ_LL: begin
        prod    <= 32'(a_lo) * 32'(a_lo);
        sub_reg <= 27'(ss_reg) * 27'(UER_SPACING_SCALE);
      end
      STEP_SQ_HL: begin
        prod <= 32'(a_hi) * 32'(a_lo);
        acc  <= {32'd0, prod};
      end
      STEP_SQ_HH: begin
        prod <= 32'(a_hi) * 32'(a_hi);
        acc  <= acc + {15'd0, prod, 17'd0};
      end
      STEP_SQ_ACC: begin
        acc <= acc + {prod, 32'd0};
      end
      STEP_RAD: begin
        // negative radicand clamps to zero
        rad <= (acc > {37'd0, sub_reg}) ? SQ_W'(acc - {37'd0, sub_reg}) : '0;
      end
      STEP_DIV: begin
        big  <= 32'(root) >= UER_SAT_ROOT;
        quot <= div_prod[UER_RECIP_SHIFT +: 16];
      end
      default: ;
    endcase
  end

  uer_isqrt #(
    .ROOT_W (A_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.step == STEP_ROOT_GO),
    .radicand (rad),
    .root     (root),
    .done     (root_done)
  );

  // offset and saturation
  assign sum     = 17'(quot) + 17'(cfg.offset_mm);
  assign dist_ok = (big || sum[16]) ? UER_DIST_MAX : sum[15:0];

  // stored measurement update
  always_comb begin
    last_distance_next = last_distance;
    timeout_seen_next  = timeout_seen;
    far_flag_next      = far_flag;
    near_flag_next     = near_flag;
    case (cmd.fin)
      FIN_TIMEOUT: begin
        last_distance_next = '0;
        timeout_seen_next  = 1'b1;
        far_flag_next      = 1'b0;
        near_flag_next     = 1'b0;
      end
      FIN_OK: begin
        last_distance_next = dist_ok;
        timeout_seen_next  = 1'b0;
        far_flag_next      = dist_ok >= cfg.near_threshold_mm;
        near_flag_next     = (dist_ok < cfg.near_threshold_mm) && (dist_ok != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
      timeout_seen  <= 1'b0;
      far_flag      <= 1'b0;
      near_flag     <= 1'b0;
    end else begin
      last_distance <= last_distance_next;
      timeout_seen  <= timeout_seen_next;
      far_flag      <= far_flag_next;
      near_flag     <= near_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.trigger_level <= cmd.out_trig;
      res.busy_res      <= cmd.out_busy;
      res.done_res      <= cmd.out_done;
      res.timed_out     <= timeout_seen_next;
      res.distance_mm   <= last_distance_next;
      res.far_flag      <= far_flag_next;
      res.near_flag     <= near_flag_next;
    end
  end

endmodule

@@ hw/rtl/uer_ctrl.sv @@
// ----------------------------------------------------------------------------
// uer_ctrl
// measurement phase tracking and distance calculation sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_macros.svh"

module uer_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  input  logic               tick_start,
  input  logic               tick_echo,
  output logic               tick_ready,
  output logic               res_valid,
  input  logic               res_ready,
  output uer_pkg::uer_cmd_t  cmd,
  input  uer_pkg::uer_stat_t st
);
  import uer_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  typedef enum logic [3:0] {
    ST_TICK,
    ST_SQ_A,
    ST_SQ_LL,
    ST_SQ_HL,
    ST_SQ_HH,
    ST_SQ_ACC,
    ST_RAD,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  phase_t phase;
  phase_t phase_next;
  logic   res_valid_next;
  logic   fire;

  // in the tick state, a tick is taken once the result register is free or being emptied
  assign tick_ready = (state == ST_TICK) && (!res_valid || res_ready);
  assign fire       = tick_valid && tick_ready;

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    cmd.cnt_op   = CNT_HOLD;
    cmd.step     = STEP_NONE;
    cmd.fin      = FIN_NONE;
    cmd.out_load = 1'b0;
    cmd.out_done = 1'b0;

    unique case (state)
      ST_TICK: begin
        if (fire) begin
          cmd.out_load = 1'b1;
          unique case (phase)
            PH_IDLE: begin
              if (tick_start) begin
                phase_next = PH_TRIG;
                cmd.cnt_op = CNT_LOAD1;
              end
            end
            PH_TRIG: begin
              if (st.trig_done) begin
                phase_next = PH_RISE;
                cmd.cnt_op = CNT_CLEAR;
              end else begin
                cmd.cnt_op = CNT_UP;
              end
            end
            PH_RISE: begin
              if (tick_echo) begin
                if (st.one_timeout) begin
                  phase_next   = PH_IDLE;
                  cmd.fin      = FIN_TIMEOUT;
                  cmd.out_done = 1'b1;
                end else begin
                  phase_next = PH_FALL;
                  cmd.cnt_op = CNT_LOAD1;
                end
              end else if (st.up_timeout) begin
                phase_next   = PH_IDLE;
                cmd.fin      = FIN_TIMEOUT;
                cmd.out_done = 1'b1;
              end else begin
                cmd.cnt_op = CNT_UP;
              end
            end
            PH_FALL: begin
              if (tick_echo) begin
                if (st.up_timeout) begin
                  phase_next   = PH_IDLE;
                  cmd.fin      = FIN_TIMEOUT;
                  cmd.out_done = 1'b1;
                end else begin
                  cmd.cnt_op = CNT_UP;
                end
              end else begin
                // echo fell: the result waits for the distance calculation
                cmd.out_load = 1'b0;
                state_next   = ST_SQ_A;
              end
            end
          endcase
        end
      end
      ST_SQ_A: begin
        cmd.step   = STEP_SQ_A;
        state_next = ST_SQ_LL;
      end
      ST_SQ_LL: begin
        cmd.step   = STEP_SQ_LL;
        state_next = ST_SQ_HL;
      end
      ST_SQ_HL: begin
        cmd.step   = STEP_SQ_HL;
        state_next = ST_SQ_HH;
      end
      ST_SQ_HH: begin
        cmd.step   = STEP_SQ_HH;
        state_next = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        cmd.step   = STEP_SQ_ACC;
        state_next = ST_RAD;
      end
      ST_RAD: begin
        cmd.step   = STEP_RAD;
        state_next = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        cmd.step   = STEP_ROOT_GO;
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (st.root_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step   = STEP_DIV;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        phase_next   = PH_IDLE;
        cmd.fin      = FIN_OK;
        cmd.out_load = 1'b1;
        cmd.out_done = 1'b1;
        state_next   = ST_TICK;
      end
      default: begin
        state_next = ST_TICK;
      end
    endcase

    cmd.out_trig = (phase_next == PH_TRIG);
    cmd.out_busy = (phase_next != PH_IDLE);

    if (cmd.out_load) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  // state, phase and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TICK;
      phase     <= PH_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      res_valid <= res_valid_next;
    end
  end

  // checks
  `UER_ASSERT_IMP(a_no_tick_in_calc, state != ST_TICK, !tick_ready, "tick taken during calculation")
  `UER_ASSERT_NXT(a_done_goes_idle, cmd.out_load && cmd.out_done, (phase == PH_IDLE) && res_valid, "finished result without idle phase")
  `UER_ASSERT_IMP(a_root_done_waited, st.root_done, state == ST_ROOT_WAIT, "root ready outside wait state")
  `UER_ASSERT_NXT(a_calc_entry_free, fire && (phase == PH_FALL) && !tick_echo, (state == ST_SQ_A) && !res_valid, "calculation entered with result pending")

endmodule
